/* design/slsr_pkg.sv */
// ----------------------------------------------------------------------------
// slsr_pkg
// Shared types and codes for the sorted list insert/search/remove unit.
// ----------------------------------------------------------------------------
package slsr_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  typedef struct packed {
    logic                     cmp_en;
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* design/sorted_list_insert_search_remove_unit.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_search_remove_unit
// Bounded ascending store of signed values with insert, search and remove.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request
// passes through a compare state and an apply state whatever the fill level:
// in the first all cells compare their value against the request in
// parallel, and in the second the row shifts and the result is registered.
// The result appears in the following cycle on status, position and count,
// marked by done for exactly one cycle; the receiver cannot stall it. busy is
// high only in the compare cycle, so a new request may be issued in the cycle
// that finishes the previous one, while that one is still being applied.
module sorted_list_insert_search_remove_unit #(
  parameter int CAPACITY = slsr_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [slsr_pkg::OP_W-1:0]           operation,
  input  logic signed [slsr_pkg::DATA_W-1:0]  value,
  output logic                                done,
  output logic [slsr_pkg::STATUS_W-1:0]       status,
  output logic [slsr_pkg::POS_W-1:0]          position,
  output logic [slsr_pkg::COUNT_W-1:0]        count
);
  import slsr_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  state_t                    state, state_next;
  logic [OP_W-1:0]           req_op;
  logic signed [DATA_W-1:0]  req_val;
  logic [CNT_W-1:0]          stored_count, stored_count_next;
  cell_ctrl_t                ctrl;

  logic signed [DATA_W-1:0]  vals [CAPACITY];
  logic [CAPACITY-1:0]       lt, eq, boundary;
  logic                      full, found, accept;
  logic [IDX_W-1:0]          pos_idx;
  logic [IDX_W+POS_W-1:0]    pos_ext;
  logic [CNT_W+COUNT_W-1:0]  cnt_ext;
  logic [STATUS_W-1:0]       res_status;
  logic                      res_has_pos;

  assign busy   = (state == ST_CMP);
  assign accept = start && !busy;
  assign full   = (stored_count >= CNT_W'(CAPACITY));
  assign found  = |(boundary & eq);

  assign ctrl.cmp_en = (state == ST_CMP);
  assign ctrl.ins    = (state == ST_APPLY) && (req_op == OP_INSERT) && !full;
  assign ctrl.rem    = (state == ST_APPLY) && (req_op == OP_REMOVE) && found;
  assign ctrl.value  = req_val;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     left_lt;
    logic signed [DATA_W-1:0] left_val, right_val;

    if (k == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = req_val;
    end else begin : g_mid
      assign left_lt  = lt[k-1];
      assign left_val = vals[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_val = vals[k];
    end else begin : g_inner
      assign right_val = vals[k+1];
    end

    assign boundary[k] = left_lt && !lt[k];

    slsr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (CNT_W'(k) < stored_count),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[k]),
      .lt        (lt[k]),
      .eq        (eq[k])
    );
  end

  always_comb begin
    pos_idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (boundary[k]) pos_idx = pos_idx | IDX_W'(k);
    end
    pos_ext = {{POS_W{1'b0}}, pos_idx};
  end

  always_comb begin
    res_status        = STATUS_NOT_FOUND;
    res_has_pos       = 1'b0;
    stored_count_next = stored_count;
    unique case (req_op) inside
      OP_INSERT: begin
        if (full) begin
          res_status = STATUS_FULL;
        end else begin
          res_status        = STATUS_OK;
          res_has_pos       = 1'b1;
          stored_count_next = stored_count + CNT_W'(1);
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (found) begin
          res_status  = STATUS_OK;
          res_has_pos = 1'b1;
          if (req_op == OP_REMOVE) stored_count_next = stored_count - CNT_W'(1);
        end
      end
      default: ;
    endcase
    cnt_ext = {{COUNT_W{1'b0}}, stored_count_next};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CMP;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: state_next = start ? ST_CMP : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (state == ST_APPLY) stored_count <= stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= operation;
      req_val <= value;
    end
    if (state == ST_APPLY) begin
      status   <= res_status;
      position <= res_has_pos ? pos_ext[POS_W-1:0] : '0;
      count    <= cnt_ext[COUNT_W-1:0];
    end
  end

endmodule

/* design/slsr_cell.sv */
// ----------------------------------------------------------------------------
// slsr_cell
// One slot of the sorted row: compares against the request value and shifts
// toward or away from its neighbors.
// ----------------------------------------------------------------------------
module slsr_cell (
  input  logic                              clk,
  input  slsr_pkg::cell_ctrl_t              ctrl,
  input  logic                              occ,
  input  logic                              left_lt,
  input  logic signed [slsr_pkg::DATA_W-1:0] left_val,
  input  logic signed [slsr_pkg::DATA_W-1:0] right_val,
  output logic signed [slsr_pkg::DATA_W-1:0] val,
  output logic                              lt,
  output logic                              eq
);
  import slsr_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= occ && (val < ctrl.value);
      eq <= occ && (val == ctrl.value);
    end
    if (ctrl.ins && !lt) begin
      val <= left_lt ? ctrl.value : left_val;
    end else if (ctrl.rem && !lt) begin
      val <= right_val;
    end
  end

endmodule

/* design/slsr_checker.sv */
// ----------------------------------------------------------------------------
// slsr_checker
// Port-level checks on request timing and result codes, bound to the top.
// ----------------------------------------------------------------------------
module slsr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [slsr_pkg::STATUS_W-1:0]  status,
  input logic [slsr_pkg::POS_W-1:0]     position
);
  import slsr_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_result_after: assert property (@(posedge clk) disable iff (rst)
    busy |=> ##1 done)
    else $error("result beat missing two cycles after compare");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_OK || status == STATUS_NOT_FOUND || status == STATUS_FULL))
    else $error("illegal status code");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_OK |-> position == '0)
    else $error("position nonzero on a miss");

endmodule

bind sorted_list_insert_search_remove_unit slsr_checker u_slsr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .position (position)
);
